// File: rtl/rgbwlpc_pkg.sv
// ----------------------------------------------------------------------------
// rgbwlpc_pkg
// Types, codes and helpers shared by the RGBW lamp palette controller.
// ----------------------------------------------------------------------------
package rgbwlpc_pkg;

	localparam int PALETTE_DEPTH_DEF = 16;

	localparam int LEN_W     = 5;   // palette length register and index width
	localparam int IDX_W     = 4;   // reported color index width
	localparam int DIV_W     = 16;  // dividend width of the remainder unit
	localparam int DIV_CNT_W = 4;   // iteration counter of the remainder unit
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;

	localparam logic [31:0] HB_INTERVAL_RST = 32'd10000;

	// Input modes.
	localparam logic [2:0] MODE_TICK     = 3'd0;
	localparam logic [2:0] MODE_STEP     = 3'd1;
	localparam logic [2:0] MODE_TOGGLE   = 3'd2;
	localparam logic [2:0] MODE_SET_RGBW = 3'd3;
	localparam logic [2:0] MODE_SIGNAL   = 3'd4;
	localparam logic [2:0] MODE_LOAD     = 3'd5;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PALETTE_LENGTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_MEANS_ON   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WHITE_PRESENT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STANDBY_EN     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HB_INTERVAL    = 3'd4;

	typedef struct packed {
		logic [2:0]         mode;
		logic [31:0]        now_ms;
		logic signed [15:0] step_amount;
		logic [15:0]        signal_value;
		logic [3:0]         entry_slot;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic [7:0]         white;
	} in_word_t;

	typedef struct packed {
		logic [15:0]      duty_red;
		logic [15:0]      duty_green;
		logic [15:0]      duty_blue;
		logic [15:0]      duty_white;
		logic             duties_updated;
		logic             lamp_active;
		logic [IDX_W-1:0] color_index;
		logic             heartbeat;
		logic             changed;
	} out_word_t;

	// Polarity, then widening of a channel byte to a 16-bit duty.
	function automatic logic [15:0] widen(input logic [7:0] v, input logic pass);
		logic [7:0] b;
		b = pass ? v : ~v;
		return (b == 8'hFF) ? 16'hFFFF : {b, 8'h00};
	endfunction

endpackage

// File: rtl/rgbwlpc_if.sv
// ----------------------------------------------------------------------------
// rgbwlpc_in_if / rgbwlpc_out_if
// Valid/ready channels carrying command words and result words.
// ----------------------------------------------------------------------------
interface rgbwlpc_in_if;
	import rgbwlpc_pkg::*;
	logic     valid;
	logic     ready;
	in_word_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface rgbwlpc_out_if;
	import rgbwlpc_pkg::*;
	logic      valid;
	logic      ready;
	out_word_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: rtl/rgbwlpc_remdiv.sv
// ----------------------------------------------------------------------------
// rgbwlpc_remdiv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module rgbwlpc_remdiv (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rgbwlpc_pkg::DIV_W-1:0] dividend,
	input  logic [rgbwlpc_pkg::LEN_W-1:0] divisor,
	output logic                          done,
	output logic [rgbwlpc_pkg::LEN_W-1:0] remainder
);
	import rgbwlpc_pkg::*;

	logic                 run_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     dvd_q;
	logic [LEN_W-1:0]     div_q;
	logic [LEN_W-1:0]     rem_q;
	logic [LEN_W:0]       trial;

	// The partial remainder stays below the divisor, so one extra bit suffices.
	assign trial = {rem_q, dvd_q[DIV_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DIV_CNT_W'(DIV_W - 1);
		end else if (run_q) begin
			if (cnt_q == '0) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
			cnt_q <= cnt_q - 1'b1;
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				rem_q <= LEN_W'(trial - {1'b0, div_q});
			end else begin
				rem_q <= trial[LEN_W-1:0];
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

// File: rtl/rgbw_lamp_palette_controller.sv
// ----------------------------------------------------------------------------
// rgbw_lamp_palette_controller
// RGBW lamp controller with a palette memory, polarity, duty widening and
// heartbeat / change reporting on ticks.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake     | Word
//  in_ch    | sink      | valid/ready   | command (mode, time, step, colour)
//  out_ch   | source    | valid/ready   | duties and status, one per command
//  cfg_*    | write     | cfg_we        | register index and data
//
//  Tick, set, load and toggle-off commands go from acceptance straight to the
//  done state. Step, signal and toggle-on first run the bit-serial remainder
//  unit, followed by one palette memory read.
//  One command is in work at a time; the next is accepted once the result is
//  handed to the output register, which may still be waiting on out_ch.
//  Reset clears all control state; the palette memory is not cleared.
// ----------------------------------------------------------------------------
module rgbw_lamp_palette_controller #(
	parameter int PALETTE_DEPTH = rgbwlpc_pkg::PALETTE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	rgbwlpc_in_if.sink                        in_ch,
	rgbwlpc_out_if.source                     out_ch,
	input  logic                              cfg_we,
	input  logic [rgbwlpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rgbwlpc_pkg::CFG_DAT_W-1:0] cfg_wdata
);
	import rgbwlpc_pkg::*;

	localparam int AW      = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam int LEN_CAP = (PALETTE_DEPTH < 31) ? PALETTE_DEPTH : 31;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_DIV  = 4'b0010,
		S_RD   = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [LEN_W-1:0] plen_q;
	logic             low_on_q;
	logic             white_q;
	logic             standby_q;
	logic [31:0]      hb_interval_q;

	// Lamp state.
	logic [IDX_W-1:0] last_idx_q;
	logic             active_q;
	logic             chg_q;
	logic [31:0]      last_hb_q;
	logic [15:0]      duty_r_q, duty_g_q, duty_b_q, duty_w_q;

	logic [31:0] palette_mem [PALETTE_DEPTH];
	logic [31:0] rdata_q;

	in_word_t         item_q;
	logic             use_mem_q;
	logic             neg_q;
	logic [LEN_W-1:0] idx_q;

	logic      out_valid_q;
	out_word_t out_data_q;

	logic [LEN_W-1:0] eff_len;
	logic             accept;
	logic             done_fire;

	// Remainder unit hookup.
	logic             div_start;
	logic [DIV_W-1:0] div_dividend;
	logic             div_done;
	logic [LEN_W-1:0] div_rem;
	logic             neg_c;
	logic signed [15:0] step_c;
	logic signed [16:0] sum_c;

	// Result computation.
	logic        show_c;
	logic        tick_c;
	logic        beat_c;
	logic [31:0] color_c;
	logic [31:0] elapsed_c;
	logic        nxt_active;
	logic [15:0] nxt_r, nxt_g, nxt_b, nxt_w;
	logic [IDX_W-1:0] nxt_idx;

	always_comb begin
		if (plen_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (int'(plen_q) > PALETTE_DEPTH) begin
			eff_len = LEN_W'(LEN_CAP);
		end else begin
			eff_len = plen_q;
		end
	end

	assign in_ch.ready = (state_q == S_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign done_fire   = (state_q == S_DONE) && (!out_valid_q || out_ch.ready);

	// Dividend for the commands that select a palette entry. A step is taken
	// by magnitude; a negative sum is folded back after the remainder.
	always_comb begin
		step_c       = (in_ch.data.step_amount == '0) ? 16'sd1 : in_ch.data.step_amount;
		sum_c        = $signed({13'b0, last_idx_q}) + 17'(step_c);
		neg_c        = 1'b0;
		div_start    = 1'b0;
		div_dividend = '0;
		case (in_ch.data.mode)
			MODE_STEP: begin
				div_start    = accept;
				neg_c        = sum_c[16];
				div_dividend = sum_c[16] ? DIV_W'(-sum_c) : sum_c[DIV_W-1:0];
			end
			MODE_SIGNAL: begin
				div_start    = accept;
				div_dividend = in_ch.data.signal_value;
			end
			MODE_TOGGLE: begin
				div_start    = accept && !active_q;
				div_dividend = DIV_W'(last_idx_q);
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	rgbwlpc_remdiv u_remdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (eff_len),
		.done      (div_done),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= div_start ? S_DIV : S_DONE;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (done_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q    <= in_ch.data;
			use_mem_q <= div_start;
			neg_q     <= neg_c;
		end
		if (state_q == S_DIV && div_done) begin
			idx_q <= (neg_q && div_rem != '0) ? LEN_W'(eff_len - div_rem) : div_rem;
		end
	end

	// Palette memory: written on load commands, read into a register in the read state ahead of use in the done state.
	always_ff @(posedge clk) begin
		if (done_fire && item_q.mode == MODE_LOAD && int'(item_q.entry_slot) < PALETTE_DEPTH) begin
			palette_mem[AW'(item_q.entry_slot)] <= {item_q.white, item_q.blue,
				item_q.green, item_q.red};
		end
		if (state_q == S_RD) begin
			rdata_q <= palette_mem[AW'(idx_q)];
		end
	end

	always_comb begin
		show_c = 1'b0;
		tick_c = 1'b0;
		case (item_q.mode) inside
			MODE_TICK: begin
				tick_c = 1'b1;
			end
			MODE_STEP, MODE_TOGGLE, MODE_SET_RGBW, MODE_SIGNAL: begin
				show_c = 1'b1;
			end
			default: begin
				show_c = 1'b0;
			end
		endcase

		if (use_mem_q) begin
			color_c = rdata_q;
		end else if (item_q.mode == MODE_SET_RGBW) begin
			color_c = {item_q.white, item_q.blue, item_q.green, item_q.red};
		end else begin
			color_c = '0;
		end

		elapsed_c = item_q.now_ms - last_hb_q;
		beat_c    = tick_c && standby_q && active_q && (elapsed_c > hb_interval_q);

		nxt_active = show_c ? (color_c != '0) : active_q;
		nxt_r = show_c ? widen(color_c[7:0], low_on_q) : duty_r_q;
		nxt_g = show_c ? widen(color_c[15:8], low_on_q) : duty_g_q;
		nxt_b = show_c ? widen(color_c[23:16], low_on_q) : duty_b_q;
		nxt_w = (show_c && white_q) ? widen(color_c[31:24], low_on_q) : duty_w_q;
		nxt_idx = use_mem_q ? idx_q[IDX_W-1:0] : last_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_idx_q <= '0;
			active_q   <= 1'b0;
			chg_q      <= 1'b1;
			last_hb_q  <= '0;
			duty_r_q   <= '0;
			duty_g_q   <= '0;
			duty_b_q   <= '0;
			duty_w_q   <= '0;
		end else if (done_fire) begin
			last_idx_q <= nxt_idx;
			active_q   <= nxt_active;
			duty_r_q   <= nxt_r;
			duty_g_q   <= nxt_g;
			duty_b_q   <= nxt_b;
			duty_w_q   <= nxt_w;
			if (show_c) begin
				chg_q <= 1'b1;
			end else if (tick_c) begin
				chg_q <= 1'b0;
			end
			if (beat_c) begin
				last_hb_q <= item_q.now_ms;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q        <= LEN_W'(1);
			low_on_q      <= 1'b1;
			white_q       <= 1'b1;
			standby_q     <= 1'b0;
			hb_interval_q <= HB_INTERVAL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PALETTE_LENGTH: plen_q        <= cfg_wdata[LEN_W-1:0];
				REG_LOW_MEANS_ON:   low_on_q      <= cfg_wdata[0];
				REG_WHITE_PRESENT:  white_q       <= cfg_wdata[0];
				REG_STANDBY_EN:     standby_q     <= cfg_wdata[0];
				REG_HB_INTERVAL:    hb_interval_q <= cfg_wdata[31:0];
				default: begin
					plen_q <= plen_q;
				end
			endcase
		end
	end

	// Output register; a finished word waits here while the next command runs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			out_data_q.duty_red       <= nxt_r;
			out_data_q.duty_green     <= nxt_g;
			out_data_q.duty_blue      <= nxt_b;
			out_data_q.duty_white     <= nxt_w;
			out_data_q.duties_updated <= show_c;
			out_data_q.lamp_active    <= nxt_active;
			out_data_q.color_index    <= nxt_idx;
			out_data_q.heartbeat      <= beat_c;
			out_data_q.changed        <= tick_c && chg_q;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_data_q;

endmodule
